@@ rtl/smch_pkg.sv @@
// Package for the synchronous memory card host: sequence steps, pin primitives,
// card command bytes and the item payload types. No dependencies.
`default_nettype none
package smch_pkg;

    typedef enum logic [4:0] {
        ST_IDLE = 5'd0,  R_ATR   = 5'd1,  R_CMD   = 5'd2,  R_RECV  = 5'd3,
        R_BRK   = 5'd4,  V_ATR1  = 5'd5,  V_CMD1  = 5'd6,  V_RECV1 = 5'd7,
        V_BRK1  = 5'd8,  V_ATR2  = 5'd9,  V_WEC   = 5'd10, V_P1    = 5'd11,
        V_C1    = 5'd12, V_P2    = 5'd13, V_C2    = 5'd14, V_P3    = 5'd15,
        V_C3    = 5'd16, V_P4    = 5'd17, V_WFF   = 5'd18, V_P5    = 5'd19,
        V_ATR3  = 5'd20, V_CMD3  = 5'd21, V_RECV3 = 5'd22, V_BRK3  = 5'd23,
        W_ATR   = 5'd24, W_CMD   = 5'd25, W_PROC  = 5'd26
    } t_step;

    typedef enum logic [2:0] {
        PR_ATR = 3'd0, PR_CMD = 3'd1, PR_RECV = 3'd2, PR_BRK = 3'd3, PR_PROC = 3'd4
    } t_prim;

    localparam logic [1:0] CMD_NONE   = 2'd0;
    localparam logic [1:0] CMD_READ   = 2'd1;
    localparam logic [1:0] CMD_WRITE  = 2'd2;
    localparam logic [1:0] CMD_VERIFY = 2'd3;

    localparam logic [1:0] STS_OK = 2'd0, STS_NOCARD = 2'd1;
    localparam logic [1:0] STS_FAIL = 2'd2, STS_PROT = 2'd3;

    localparam logic [1:0] VC_OK = 2'd0, VC_CARD = 2'd1;
    localparam logic [1:0] VC_MISMATCH = 2'd2, VC_REFUSED = 2'd3;

    localparam logic [7:0] CB_READ_MAIN  = 8'h30;
    localparam logic [7:0] CB_READ_SEC   = 8'h31;
    localparam logic [7:0] CB_COMPARE    = 8'h33;
    localparam logic [7:0] CB_WRITE_MAIN = 8'h38;
    localparam logic [7:0] CB_WRITE_SEC  = 8'h39;
    localparam logic [7:0] EC_ALL        = 8'hff;
    localparam logic [7:0] PROT_LIMIT    = 8'd32;

    localparam logic [1:0] REG_PASSWORD = 2'd0;
    localparam logic [1:0] REG_ANSWER   = 2'd1;
    localparam logic [1:0] REG_PHASE    = 2'd2;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] address;
        logic [7:0] length;
        logic [7:0] write_data;
        logic       io_sense;
        logic       card_present;
    } t_in_item;

    typedef struct packed {
        logic       card_clock;
        logic       card_reset;
        logic       io_drive;
        logic       io_level;
        logic       busy_res;
        logic       done_res;
        logic [1:0] status;
        logic [1:0] verify_code;
        logic [7:0] read_data;
        logic       read_valid;
        logic       last_byte;
    } t_out_item;

endpackage
`default_nettype wire

@@ rtl/smch_stream_if.sv @@
// Valid/ready stream interface used for the input and result channels.
// Depends on smch_pkg for nothing; payload type is a parameter.
`default_nettype none
interface smch_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/sync_memory_card_host.sv @@
// Synchronous memory card host: one input transaction is one pin-sequencer tick.
// Each accepted tick's result is registered in the output register.
// Throughput: one tick per cycle; the input stalls only while a result waits.
// Reset (synchronous, active low): sequencer idle, pins low, registers at defaults.
// Depends on smch_pkg and smch_stream_if.
`default_nettype none
module sync_memory_card_host (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    smch_stream_if.sink      s_in,
    smch_stream_if.source    m_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    import smch_pkg::*;

    logic [23:0] r_password;
    logic [31:0] r_answer;
    logic [15:0] r_phase_ticks;

    t_step       r_step, n_step;
    t_prim       r_prim, n_prim;
    logic [11:0] r_ph, n_ph;
    logic [15:0] r_timer, n_timer;
    logic [4:0]  r_bits, n_bits;
    logic [7:0]  r_bytes, n_bytes;
    logic [31:0] r_shift, n_shift;
    logic [7:0]  r_ec, n_ec;
    logic [25:0] r_req, n_req;
    logic [23:0] r_cmdw, n_cmdw;
    logic [8:0]  r_nrecv, n_nrecv;
    logic [3:0]  r_pins, n_pins;
    logic [1:0]  r_sts, n_sts, r_vc, n_vc;

    t_out_item   r_out, n_out;
    logic        r_out_v;

    t_in_item    in;
    logic        acc;
    logic        done, vld, lst;
    logic [7:0]  dat;

    assign pready = 1'b1;
    assign in     = s_in.data;
    assign s_in.ready = !r_out_v || m_out.ready;
    assign acc    = s_in.valid && s_in.ready;
    assign m_out.valid = r_out_v;
    assign m_out.data  = r_out;

    always_comb begin
        unique case (paddr[3:2])
            REG_PASSWORD: prdata = {8'd0, r_password};
            REG_ANSWER:   prdata = r_answer;
            REG_PHASE:    prdata = {16'd0, r_phase_ticks};
            default:      prdata = 32'd0;
        endcase
    end

    function automatic logic [3:0] pins_of(t_prim p, logic [11:0] ph, logic [23:0] cw);
        logic [11:0] k;
        logic        c, r, d, l;
        begin
            k = ph - 12'd3;
            c = 1'b0; r = 1'b0; d = 1'b0; l = 1'b0;
            unique case (p)
                PR_ATR: begin
                    if (ph < 12'd5) begin
                        c = (ph == 12'd2);
                        r = (ph != 12'd0) && (ph != 12'd4);
                    end else begin
                        c = ~ph[0];
                    end
                end
                PR_CMD: begin
                    d = 1'b1;
                    if (ph < 12'd3) begin
                        c = (ph >= 12'd1); l = (ph < 12'd2);
                    end else if (ph < 12'd51) begin
                        c = k[0]; l = cw[k[5:1]];
                    end else begin
                        c = (ph >= 12'd52); l = (ph == 12'd53);
                    end
                end
                PR_BRK: r = (ph == 12'd1);
                default: c = ph[0];
            endcase
            pins_of = {c, r, d, d & l};
        end
    endfunction

    always_comb begin
        logic [15:0] per;
        logic        fin, ok;
        logic [7:0]  b, b1, b2, b3;
        logic [2:0]  ec3;
        t_step       go;
        logic        do_go, do_fin;
        logic [1:0]  fs, fv;
        logic [1:0]  vres;
        logic        do_vres;

        n_step = r_step; n_prim = r_prim; n_ph = r_ph; n_timer = r_timer;
        n_bits = r_bits; n_bytes = r_bytes; n_shift = r_shift; n_ec = r_ec;
        n_req = r_req; n_cmdw = r_cmdw; n_nrecv = r_nrecv; n_pins = r_pins;
        n_sts = r_sts; n_vc = r_vc;
        done = 1'b0; vld = 1'b0; lst = 1'b0; dat = 8'd0;
        per = (r_phase_ticks == 16'd0) ? 16'd1 : r_phase_ticks;
        fin = 1'b0; ok = 1'b1; b = 8'd0;
        b1 = 8'd0; b2 = 8'd0; b3 = 8'd0;
        ec3 = r_shift[2:0];
        go = ST_IDLE; do_go = 1'b0; do_fin = 1'b0; fs = STS_OK; fv = VC_OK;
        vres = VC_OK; do_vres = 1'b0;

        if (r_step == ST_IDLE) begin
            if (in.command != CMD_NONE) begin
                n_req = {in.write_data, in.length, in.address, in.command};
                n_sts = STS_OK; n_vc = VC_OK;
                if (in.command != CMD_VERIFY && in.address < PROT_LIMIT) begin
                    do_fin = 1'b1; fs = STS_PROT;
                end else if (!in.card_present) begin
                    do_fin = 1'b1; fs = STS_NOCARD;
                    fv = (in.command == CMD_VERIFY) ? VC_CARD : VC_OK;
                end else begin
                    do_go = 1'b1;
                    go = (in.command == CMD_READ) ? R_ATR : V_ATR1;
                end
            end
        end else begin
            n_timer = r_timer + 16'd1;
            if (n_timer >= per) begin
                n_timer = 16'd0;
                unique case (r_prim)
                    PR_ATR: begin
                        if (r_ph >= 12'd5 && r_ph[0] == 1'b0) begin
                            n_shift = {in.io_sense, r_shift[31:1]};
                            n_bits = r_bits + 5'd1;
                        end
                        n_ph = r_ph + 12'd1;
                        if (n_ph >= 12'd69) begin
                            fin = 1'b1; ok = (n_shift == r_answer);
                        end
                    end
                    PR_CMD: begin
                        n_ph = r_ph + 12'd1; fin = (n_ph >= 12'd54);
                    end
                    PR_RECV: begin
                        if (r_ph[0]) begin
                            b = {in.io_sense, r_shift[7:1]};
                            n_shift = {24'd0, b};
                            n_bits = r_bits + 5'd1;
                            if (n_bits >= 5'd8) begin
                                n_bits = 5'd0;
                                n_bytes = r_bytes + 8'd1;
                                if (r_step == R_RECV) begin
                                    vld = 1'b1; dat = b;
                                    lst = ({1'b0, n_bytes} >= r_nrecv);
                                end
                            end
                        end
                        n_ph = r_ph + 12'd1;
                        fin = (n_ph >= {r_nrecv, 4'd0} - 12'd0);
                    end
                    PR_BRK: begin
                        n_ph = r_ph + 12'd1; fin = (n_ph >= 12'd2);
                    end
                    default: begin
                        if (r_ph == 12'd0) begin
                            if (in.io_sense) fin = 1'b1; else n_ph = 12'd1;
                        end else n_ph = 12'd0;
                    end
                endcase
                if (fin) begin
                    unique case (r_step)
                        R_ATR, W_ATR: begin
                            if (ok) begin
                                do_go = 1'b1; go = (r_step == R_ATR) ? R_CMD : W_CMD;
                            end else begin
                                do_fin = 1'b1; fs = STS_FAIL;
                            end
                        end
                        R_CMD: begin
                            do_go = 1'b1; go = (r_req[17:10] == 8'd0) ? R_BRK : R_RECV;
                        end
                        R_BRK, W_PROC: do_fin = 1'b1;
                        V_ATR1, V_ATR2, V_ATR3: begin
                            if (ok) begin
                                do_go = 1'b1; go = t_step'(r_step + 5'd1);
                            end else begin
                                do_vres = 1'b1; vres = VC_CARD;
                            end
                        end
                        V_BRK1: begin
                            if (ec3 == 3'd1 || ec3 == 3'd2 || ec3 == 3'd4) begin
                                do_vres = 1'b1; vres = VC_REFUSED;
                            end else if (ec3 == 3'd0) begin
                                do_vres = 1'b1; vres = VC_CARD;
                            end else begin
                                n_ec = (ec3 == 3'd7) ? 8'd3 : (ec3 == 3'd6) ? 8'd2 : 8'd1;
                                do_go = 1'b1; go = V_ATR2;
                            end
                        end
                        V_BRK3: begin
                            n_ec = r_shift[7:0];
                            do_vres = 1'b1;
                            vres = (ec3 == 3'd7) ? VC_OK : VC_MISMATCH;
                        end
                        default: begin
                            do_go = 1'b1; go = t_step'(r_step + 5'd1);
                        end
                    endcase
                end else begin
                    n_pins = pins_of(r_prim, n_ph, r_cmdw);
                end
            end
        end

        if (do_vres) begin
            if (r_req[1:0] == CMD_VERIFY) begin
                do_fin = 1'b1; fv = vres; fs = (vres == VC_OK) ? STS_OK : STS_FAIL;
            end else if (vres != VC_OK) begin
                do_fin = 1'b1; fv = vres; fs = STS_FAIL;
            end else begin
                do_go = 1'b1; go = W_ATR;
            end
        end

        if (do_fin) begin
            n_step = ST_IDLE; n_timer = 16'd0; n_sts = fs; n_vc = fv;
            done = 1'b1; n_pins = 4'd0;
        end else if (do_go) begin
            n_step = go; n_ph = 12'd0; n_timer = 16'd0; n_bits = 5'd0; n_bytes = 8'd0;
            unique case (go)
                R_ATR, V_ATR1, V_ATR2, V_ATR3, W_ATR: begin
                    n_prim = PR_ATR; n_shift = 32'd0;
                end
                R_RECV, V_RECV1, V_RECV3: begin
                    n_prim = PR_RECV; n_shift = 32'd0;
                    n_nrecv = (go == R_RECV) ? {1'b0, n_req[17:10]} : 9'd1;
                end
                R_BRK, V_BRK1, V_BRK3: n_prim = PR_BRK;
                V_P1, V_P2, V_P3, V_P4, V_P5, W_PROC: n_prim = PR_PROC;
                default: begin
                    n_prim = PR_CMD;
                    unique case (go)
                        R_CMD: begin b1 = CB_READ_MAIN; b2 = n_req[9:2]; end
                        V_WEC: begin b1 = CB_WRITE_SEC; b3 = n_ec; end
                        V_C1: begin b1 = CB_COMPARE; b2 = 8'd1; b3 = r_password[7:0]; end
                        V_C2: begin b1 = CB_COMPARE; b2 = 8'd2; b3 = r_password[15:8]; end
                        V_C3: begin b1 = CB_COMPARE; b2 = 8'd3; b3 = r_password[23:16]; end
                        V_WFF: begin b1 = CB_WRITE_SEC; b3 = EC_ALL; end
                        W_CMD: begin b1 = CB_WRITE_MAIN; b2 = n_req[9:2]; b3 = n_req[25:18]; end
                        default: b1 = CB_READ_SEC;
                    endcase
                    n_cmdw = {b3, b2, b1};
                end
            endcase
            n_pins = pins_of(n_prim, 12'd0, n_cmdw);
        end

        n_out.card_clock  = n_pins[3];
        n_out.card_reset  = n_pins[2];
        n_out.io_drive    = n_pins[1];
        n_out.io_level    = n_pins[0];
        n_out.busy_res    = (n_step != ST_IDLE);
        n_out.done_res    = done;
        n_out.status      = n_sts;
        n_out.verify_code = n_vc;
        n_out.read_data   = dat;
        n_out.read_valid  = vld;
        n_out.last_byte   = lst;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_password <= 24'hffffff; r_answer <= 32'd0; r_phase_ticks <= 16'd250;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                REG_PASSWORD: r_password <= pwdata[23:0];
                REG_ANSWER:   r_answer <= pwdata;
                REG_PHASE:    r_phase_ticks <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_IDLE; r_prim <= PR_ATR; r_ph <= 12'd0; r_timer <= 16'd0;
            r_bits <= 5'd0; r_bytes <= 8'd0; r_shift <= 32'd0; r_ec <= 8'd0;
            r_req <= 26'd0; r_cmdw <= 24'd0; r_nrecv <= 9'd0; r_pins <= 4'd0;
            r_sts <= STS_OK; r_vc <= VC_OK; r_out_v <= 1'b0;
        end else begin
            if (acc) begin
                r_step <= n_step; r_prim <= n_prim; r_ph <= n_ph; r_timer <= n_timer;
                r_bits <= n_bits; r_bytes <= n_bytes; r_shift <= n_shift; r_ec <= n_ec;
                r_req <= n_req; r_cmdw <= n_cmdw; r_nrecv <= n_nrecv; r_pins <= n_pins;
                r_sts <= n_sts; r_vc <= n_vc;
                r_out_v <= 1'b1;
            end else if (m_out.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) r_out <= n_out;
    end

    // A stalled result must not be overwritten by a new transaction.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !m_out.ready) |-> !s_in.ready) else $error("result overrun");
    // Pins are all low whenever the sequencer is idle.
    a_idle_pins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == ST_IDLE) |-> (r_pins == 4'd0)) else $error("pins active while idle");
    // A byte is only reported during a main-memory read run.
    a_read_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && vld) |-> (r_step == R_RECV)) else $error("stray read byte");

endmodule
`default_nettype wire
